// ===== hw/rtl/ils_pkg.sv =====
// Package with shared constants, codes and control types of the indexed list store.
`default_nettype none

package ils_pkg;

    // Default sizes of the store.
    localparam int DEF_CAPACITY    = 16;
    localparam int DEF_VALUE_WIDTH = 32;

    // Fixed widths of the request and result fields.
    localparam int MODE_W   = 3;
    localparam int INDEX_W  = 4;
    localparam int VALUE_W  = 32;
    localparam int RESULT_W = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Request kinds.
    typedef enum logic [MODE_W-1:0] {
        MODE_GET    = 3'd0,
        MODE_SET    = 3'd1,
        MODE_ADD    = 3'd2,
        MODE_DELETE = 3'd3,
        MODE_CLEAR  = 3'd4
    } t_mode;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;   // capture a new result
        logic    rd;     // result carries the addressed word
        logic    wr;     // replace the addressed word
        logic    app;    // append at the end
        logic    del;    // remove the addressed word and close the gap
        logic    clr;    // empty the store
        t_status status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_range;  // index lies below the fill count
        logic full;      // fill count has reached the capacity
    } t_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/ils_if.sv =====
// Request and result channel interfaces of the indexed list store.
`default_nettype none

interface ils_req_if;
    import ils_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output mode, output index, output value, input ready);
    modport sink   (input valid, input mode, input index, input value, output ready);
endinterface

interface ils_rsp_if;
    import ils_pkg::*;

    logic                valid;
    logic                ready;
    logic [RESULT_W-1:0] result_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output result_value, output status, output count,
                    input ready);
    modport sink   (input valid, input result_value, input status, input count,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ils_dp.sv =====
// Datapath of the indexed list store: row of entry cells, fill count and result register.
`default_nettype none

module ils_dp #(
    parameter int CAPACITY    = ils_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = ils_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ils_pkg::t_cmd                 i_cmd,
    input  wire logic [ils_pkg::INDEX_W-1:0]   i_index,
    input  wire logic [ils_pkg::VALUE_W-1:0]   i_value,
    output ils_pkg::t_stat                     o_stat,
    output logic [ils_pkg::RESULT_W-1:0]       o_result_value,
    output logic [ils_pkg::STATUS_W-1:0]       o_status,
    output logic [ils_pkg::COUNT_W-1:0]        o_count
);
    import ils_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    // Only the first entries are reachable through the index field.
    localparam int RD_N  = (CAPACITY < (1 << INDEX_W)) ? CAPACITY : (1 << INDEX_W);

    logic [VALUE_WIDTH-1:0] r_entries [CAPACITY];
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       n_count;
    logic [RESULT_W-1:0]    r_result_value;
    t_status                r_status;
    logic [VALUE_WIDTH-1:0] n_word;
    logic [VALUE_WIDTH-1:0] rd_word;

    assign n_word = VALUE_WIDTH'(i_value);

    always_comb begin
        rd_word = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (i_index == INDEX_W'(i)) begin
                rd_word = r_entries[i];
            end
        end
    end

    assign o_stat.in_range = CMP_W'(i_index) < CMP_W'(r_count);
    assign o_stat.full     = r_count == CNT_W'(CAPACITY);

    // Each cell loads the appended word or the replacement word; all but the last can also load their upper neighbor.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic sel_wr;
        logic sel_del;

        if (g < RD_N) begin : g_addr
            assign sel_wr = i_cmd.wr && (i_index == INDEX_W'(g));
        end else begin : g_noaddr
            assign sel_wr = 1'b0;
        end

        if (g < CAPACITY - 1) begin : g_shift
            assign sel_del = i_cmd.del && (CMP_W'(g) >= CMP_W'(i_index));
            always_ff @(posedge i_clk) begin
                if (i_cmd.app && r_count == CNT_W'(g)) begin
                    r_entries[g] <= n_word;
                end else if (sel_wr) begin
                    r_entries[g] <= n_word;
                end else if (sel_del) begin
                    r_entries[g] <= r_entries[g+1];
                end
            end
        end else begin : g_last
            assign sel_del = 1'b0;
            always_ff @(posedge i_clk) begin
                if ((i_cmd.app && r_count == CNT_W'(g)) || sel_wr || sel_del) begin
                    r_entries[g] <= n_word;
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.clr) begin
            n_count = '0;
        end else if (i_cmd.app) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_result_value <= i_cmd.rd ? RESULT_W'(rd_word) : '0;
            r_status       <= i_cmd.status;
        end
    end

    assign o_result_value = r_result_value;
    assign o_status       = r_status;
    assign o_count        = COUNT_W'(r_count);

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    a_append_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.app |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("append did not grow the fill count");

    a_delete_shrinks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.del |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("delete did not shrink the fill count");

endmodule

`default_nettype wire

// ===== hw/rtl/ils_ctrl.sv =====
// Controller of the indexed list store: request decode and result handshake.
`default_nettype none

module ils_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_req_valid,
    input  wire logic [ils_pkg::MODE_W-1:0]   i_mode,
    input  wire logic                         i_rsp_ready,
    input  wire ils_pkg::t_stat               i_stat,
    output logic                              o_req_ready,
    output logic                              o_rsp_valid,
    output ils_pkg::t_cmd                     o_cmd
);
    import ils_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // A new request may enter whenever the held result leaves in the same cycle.
    assign o_req_ready = (r_state == ST_IDLE) || i_rsp_ready;
    assign o_rsp_valid = r_state == ST_HOLD;
    assign accept      = i_req_valid && o_req_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (accept) begin
                    n_state = ST_HOLD;
                end else if (i_rsp_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.status = STATUS_OK;
        if (accept) begin
            o_cmd.load = 1'b1;
            case (i_mode)
                MODE_GET: begin
                    if (i_stat.in_range) begin
                        o_cmd.rd = 1'b1;
                    end else begin
                        o_cmd.status = STATUS_RANGE;
                    end
                end
                MODE_SET: begin
                    if (i_stat.in_range) begin
                        o_cmd.rd = 1'b1;
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.status = STATUS_RANGE;
                    end
                end
                MODE_ADD: begin
                    if (!i_stat.full) begin
                        o_cmd.app = 1'b1;
                    end else begin
                        o_cmd.status = STATUS_FULL;
                    end
                end
                MODE_DELETE: begin
                    if (i_stat.in_range) begin
                        o_cmd.rd  = 1'b1;
                        o_cmd.del = 1'b1;
                    end else begin
                        o_cmd.status = STATUS_RANGE;
                    end
                end
                MODE_CLEAR: begin
                    o_cmd.clr = 1'b1;
                end
                default: begin
                    // Unused codes change nothing and report success.
                end
            endcase
        end
    end

    a_one_update : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.wr, o_cmd.app, o_cmd.del, o_cmd.clr}))
        else $error("more than one store update in a cycle");

    a_load_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_rsp_valid)
        else $error("captured result not offered");

    a_refused_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.status != STATUS_OK) |-> !(o_cmd.wr || o_cmd.app || o_cmd.del || o_cmd.clr))
        else $error("refused request changed the store");

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_list_store.sv =====
// Top level of the indexed list store: an ordered row of words with a fill count.
//
// Usage: requests arrive on i_req (mode, index, value) and each one yields exactly
// one result on o_rsp (result_value, status, count). Both channels use a
// valid/ready handshake; a transfer happens on a rising edge with both high.
// Modes are get, set, add, delete and clear. Get, set and delete address an
// entry by index; an index at or beyond the fill count gives status "out of
// range" and value zero. Add to a full store gives status "full". Set and
// delete return the old word; count always reports the entries held after
// the request.
//
// Latency and throughput: a request is decoded and executed in the cycle it is
// accepted, and its result is offered from the output register in the next
// cycle. One request per cycle is sustained while each result is taken at once:
// the entries live in a row of register cells, so a delete moves every later
// entry down in the same cycle. A stalled receiver holds the result; a new
// request is still taken in any cycle in which the held result is taken too.
// Reset empties the store (fill count zero) and drops any pending result; no
// clearing pass is needed, since entries are never read before being written.
`default_nettype none

module indexed_list_store #(
    parameter int CAPACITY    = ils_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH = ils_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ils_req_if.sink     i_req,
    ils_rsp_if.source   o_rsp
);
    import ils_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Controller: decides what each accepted request does and tracks the result.
    ils_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_mode      (i_req.mode),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (stat),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    // Datapath: entry cells, fill count and the result register.
    ils_dp #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_index        (i_req.index),
        .i_value        (i_req.value),
        .o_stat         (stat),
        .o_result_value (o_rsp.result_value),
        .o_status       (o_rsp.status),
        .o_count        (o_rsp.count)
    );

endmodule

`default_nettype wire

// ===== tb/ils_scoreboard_pkg.sv =====
// Scoreboard for the indexed list store: tracks the stored words and checks every result.
package ils_scoreboard_pkg;
    import ils_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [RESULT_W-1:0] result_value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_list_result;

    class list_store_scoreboard;
        logic [VALUE_W-1:0] words [DEF_CAPACITY];
        int unsigned        held;
        t_list_result       awaited [$];
        int unsigned        failures;

        function new();
            held     = 0;
            failures = 0;
            foreach (words[i]) words[i] = '0;
        endfunction

        function int unsigned fill_level();
            return held;
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= REPORT_LIMIT) begin
                $display("[%0t] MISMATCH: %s", $time, msg);
            end
        endfunction

        // Applies one accepted request to the shadow store and queues its result.
        function void note_request(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] index,
                                   logic [VALUE_W-1:0] value);
            t_list_result r;
            bit           hit;
            int unsigned  pos;
            int unsigned  i;
            r   = '0;
            pos = 32'(index);
            hit = (pos < held);
            case (mode)
                MODE_GET: begin
                    if (hit) r.result_value = words[index];
                    else r.status = STATUS_RANGE;
                end
                MODE_SET: begin
                    if (hit) begin
                        r.result_value = words[index];
                        words[index]   = value;
                    end else begin
                        r.status = STATUS_RANGE;
                    end
                end
                MODE_ADD: begin
                    if (held < DEF_CAPACITY) begin
                        words[held[INDEX_W-1:0]] = value;
                        held++;
                    end else begin
                        r.status = STATUS_FULL;
                    end
                end
                MODE_DELETE: begin
                    if (hit) begin
                        r.result_value = words[index];
                        for (i = pos; i + 1 < held; i++) begin
                            words[i[INDEX_W-1:0]] = words[INDEX_W'(i + 1)];
                        end
                        held--;
                    end else begin
                        r.status = STATUS_RANGE;
                    end
                end
                MODE_CLEAR: held = 0;
                default: ;
            endcase
            r.count = held[COUNT_W-1:0];
            awaited.push_back(r);
        endfunction

        function void check_result(logic [RESULT_W-1:0] result_value,
                                   logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count);
            t_list_result want;
            if (awaited.size() == 0) begin
                report($sformatf("result with nothing pending: value %h status %0d count %0d",
                                 result_value, status, count));
                return;
            end
            want = awaited.pop_front();
            if (result_value !== want.result_value) begin
                report($sformatf("result_value expected %h actual %h",
                                 want.result_value, result_value));
            end
            if (status !== want.status) begin
                report($sformatf("status expected %0d actual %0d", want.status, status));
            end
            if (count !== want.count) begin
                report($sformatf("count expected %0d actual %0d", want.count, count));
            end
        endfunction

        function void check_drained();
            if (awaited.size() != 0) begin
                report($sformatf("%0d results never arrived", awaited.size()));
            end
        endfunction
    endclass

endpackage

// ===== tb/tb.sv =====
// Testbench top for the indexed list store: directed and random requests with handshake stalls.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ils_pkg::*;
    import ils_scoreboard_pkg::*;

    // The block offers each result from its output register in the cycle after it
    // takes the request, so the SETTLE wait at the end is plenty. The cycle limit
    // covers the slowest legal run (every request waiting out both random gaps and
    // the long hold) several times over.
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 200;
    localparam int SETTLE      = 4;

    logic i_clk;
    logic i_rst_n;

    ils_req_if req_if ();
    ils_rsp_if rsp_if ();

    indexed_list_store dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    list_store_scoreboard store_sb = new();

    // Idling controls, set by the stimulus, for the request driver and the result sink.
    bit src_idle_on;
    bit sink_idle_on;
    bit sink_hold_request;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Every result taken by the sink is checked against the oldest pending
    // expectation. Requests are noted by the driver at their acceptance edge;
    // a result always belongs to an earlier edge, so the order of the two
    // processes within one edge does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            store_sb.check_result(rsp_if.result_value, rsp_if.status, rsp_if.count);
        end
    end

    // Result sink. It draws a fresh stall before each result, or holds off for
    // a long stretch when asked to, so that the output register stays full and
    // the block has to push back on its request side.
    initial begin : result_sink
        int stall;
        rsp_if.ready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (sink_hold_request) begin
                sink_hold_request = 1'b0;
                stall = LONG_HOLD;
            end else begin
                stall = sink_idle_on ? $urandom_range(0, 10) : 0;
            end
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_if.valid) @(posedge i_clk);
        end
    end

    // Offers one request after a random gap and returns at the edge where it
    // is taken. Valid is left high so that a request that follows with no gap
    // is offered back to back; during a gap the payload carries noise that the
    // block must ignore.
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] index,
                                input logic [VALUE_W-1:0] value);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            req_if.mode  <= MODE_W'($urandom);
            req_if.index <= INDEX_W'($urandom);
            req_if.value <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode  <= mode;
        req_if.index <= index;
        req_if.value <= value;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        store_sb.note_request(mode, index, value);
    endtask

    // Withdraws the request line and waits until every result has come back.
    task automatic pause_until_drained();
        req_if.valid <= 1'b0;
        while (store_sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Random requests. The mix swings between a growing bias (mostly adds)
    // and a shrinking bias (mostly deletes) every few dozen requests, so the
    // store keeps passing through empty, partly filled and full. Indexes
    // mostly land on live entries, sometimes exactly at the fill count and
    // sometimes anywhere in the field.
    task automatic send_random(input int n);
        int unsigned        held;
        int unsigned        pick;
        int unsigned        r;
        bit                 grow;
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
        grow = 1'b1;
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0) grow = 1'($urandom_range(0, 1));
            held = store_sb.fill_level();
            pick = $urandom_range(0, 99);
            if (pick < 2) mode = MODE_CLEAR;
            else if (pick < 4) mode = MODE_W'($urandom_range(5, 7)); // unused codes
            else if (pick < (grow ? 50 : 20)) mode = MODE_ADD;
            else if (pick < (grow ? 65 : 55)) mode = MODE_DELETE;
            else if (pick < 85) mode = MODE_GET;
            else mode = MODE_SET;

            r = $urandom_range(0, 9);
            if (r < 7 && held > 0) index = INDEX_W'($urandom_range(0, held - 1));
            else if (r < 8) index = INDEX_W'((held > 15) ? 15 : held);
            else index = INDEX_W'($urandom_range(0, 15));

            r = $urandom_range(0, 9);
            if (r == 0) value = '0;
            else if (r == 1) value = '1;
            else value = $urandom;

            send_request(mode, index, value);
        end
    endtask

    initial begin : stimulus
        src_idle_on       = 1'b1;
        sink_idle_on      = 1'b1;
        sink_hold_request = 1'b0;
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.mode  <= MODE_GET;
        req_if.index <= '0;
        req_if.value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. On the empty store every indexed request is out of
        // range, and clear and the unused codes change nothing.
        send_request(MODE_GET, 4'd0, 32'h0);
        send_request(MODE_DELETE, 4'd0, 32'h0);
        send_request(MODE_SET, 4'd15, 32'hFFFF_FFFF);
        send_request(MODE_CLEAR, 4'd0, 32'h0);
        send_request(MODE_W'(7), 4'd15, 32'hFFFF_FFFF);

        // Fill the store to capacity with extreme and patterned words, then
        // try one add too many.
        for (int k = 0; k < DEF_CAPACITY; k++) begin
            case (k)
                0: send_request(MODE_ADD, 4'd15, 32'h0000_0000);
                1: send_request(MODE_ADD, 4'd0, 32'hFFFF_FFFF);
                2: send_request(MODE_ADD, 4'd5, 32'hAAAA_AAAA);
                3: send_request(MODE_ADD, 4'd10, 32'h5555_5555);
                default: send_request(MODE_ADD, INDEX_W'($urandom), $urandom);
            endcase
        end
        send_request(MODE_ADD, 4'd0, 32'h1234_5678);

        // Full store: read and replace the last entry, delete the first one so
        // every later entry moves down, then the old last index is out of range.
        send_request(MODE_GET, 4'd15, 32'h0);
        send_request(MODE_SET, 4'd15, 32'h8000_0001);
        send_request(MODE_DELETE, 4'd0, 32'h0);
        send_request(MODE_GET, 4'd15, 32'h0);
        send_request(MODE_GET, 4'd0, 32'h0);
        send_request(MODE_DELETE, 4'd14, 32'h0);
        send_request(MODE_CLEAR, 4'd0, 32'h0);
        send_request(MODE_GET, 4'd0, 32'h0);

        // Random part with both sides idling.
        send_random(300);

        // A stretch with no idling on either side.
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_random(150);

        // The sender pauses until every result is back, then the sink holds
        // off for a long time while requests keep coming with no gaps.
        pause_until_drained();
        sink_idle_on      = 1'b1;
        sink_hold_request = 1'b1;
        send_random(60);

        // Gaps on one side only, then on the other.
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b0;
        send_random(200);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b1;
        send_random(140);

        pause_until_drained();
        repeat (SETTLE) @(posedge i_clk);
        store_sb.check_drained();
        if (store_sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ils_pkg.sv
hw/rtl/ils_if.sv
hw/rtl/ils_dp.sv
hw/rtl/ils_ctrl.sv
hw/rtl/indexed_list_store.sv
tb/ils_scoreboard_pkg.sv
tb/tb.sv
